/* hw/rtl/accel_shake_detector_with_hold_assert.svh */
// Assertion macros shared by the shake detector RTL.
// Included by asd_ctrl.sv and asd_datapath.sv; needs nothing else.
`ifndef ACCEL_SHAKE_DETECTOR_WITH_HOLD_ASSERT_SVH
`define ACCEL_SHAKE_DETECTOR_WITH_HOLD_ASSERT_SVH

// same-cycle implication, disabled in reset
`define ASD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("asd assertion failed");

// next-cycle implication, disabled in reset
`define ASD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("asd assertion failed");

`endif

/* hw/rtl/asd_pkg.sv */
// Shared widths, register codes and controller/datapath structs.
// No dependencies; used by every other RTL file except the assertion macro header.
`default_nettype none

package asd_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int TIME_BITS   = 32;
   localparam int CFG_BITS    = 16;
   localparam int NET_OUT_BITS = 16;

   localparam int ROOT_BITS = SAMPLE_BITS + 1;
   localparam int SQ_BITS   = 2 * ROOT_BITS;
   localparam int REM_BITS  = ROOT_BITS + 3;
   localparam int NET_BITS  = (ROOT_BITS > CFG_BITS) ? ROOT_BITS : CFG_BITS;
   localparam int CNT_BITS  = $clog2(ROOT_BITS);
   localparam int NUM_AXES  = 3;
   localparam int SEL_BITS  = $clog2(NUM_AXES);
   localparam int IDX_BITS  = 2;

   localparam logic [IDX_BITS-1:0] REG_GRAVITY   = 2'd0;
   localparam logic [IDX_BITS-1:0] REG_THRESHOLD = 2'd1;
   localparam logic [IDX_BITS-1:0] REG_HOLD      = 2'd2;

   localparam logic [CFG_BITS-1:0] GRAVITY_RESET   = 16'd4096;
   localparam logic [CFG_BITS-1:0] THRESHOLD_RESET = 16'd1253;
   localparam logic [CFG_BITS-1:0] HOLD_RESET      = 16'd1000;

   localparam logic [SEL_BITS-1:0] AXIS_X = 2'd0;
   localparam logic [SEL_BITS-1:0] AXIS_Y = 2'd1;
   localparam logic [SEL_BITS-1:0] AXIS_Z = 2'd2;

   typedef struct packed {
      logic                load;
      logic                square;
      logic [SEL_BITS-1:0] sq_sel;
      logic                root;
      logic                net;
      logic                finish;
   } asd_cmd_type;

   typedef struct packed {
      logic out_busy;
   } asd_status_type;

endpackage

`default_nettype wire

/* hw/rtl/asd_req_if.sv */
// Request channel: one accelerometer sample with timestamp, valid/ready.
// Depends on asd_pkg.
`default_nettype none

interface asd_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [asd_pkg::SAMPLE_BITS-1:0] accel_x;
   logic signed [asd_pkg::SAMPLE_BITS-1:0] accel_y;
   logic signed [asd_pkg::SAMPLE_BITS-1:0] accel_z;
   logic [asd_pkg::TIME_BITS-1:0]        time_ms;

   modport source (output valid, accel_x, accel_y, accel_z, time_ms, input ready);
   modport sink   (input valid, accel_x, accel_y, accel_z, time_ms, output ready);
endinterface

`default_nettype wire

/* hw/rtl/asd_rsp_if.sv */
// Response channel: shake flags and net acceleration, valid/ready.
// Depends on asd_pkg.
`default_nettype none

interface asd_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             shaken;
   logic                             shake_now;
   logic [asd_pkg::NET_OUT_BITS-1:0] net_accel;
   logic                             state_changed;

   modport source (output valid, shaken, shake_now, net_accel, state_changed, input ready);
   modport sink   (input valid, shaken, shake_now, net_accel, state_changed, output ready);
endinterface

`default_nettype wire

/* hw/rtl/asd_ctrl.sv */
// Controller FSM: sequences squares, square-root iterations, net and finish.
// Depends on asd_pkg and the assertion macro header.
`default_nettype none
`include "accel_shake_detector_with_hold_assert.svh"

module asd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  asd_pkg::asd_status_type status,
   output asd_pkg::asd_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SQUARE = 5'b00010,
      ST_ROOT   = 5'b00100,
      ST_NET    = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type                      state_ff, state_in;
   logic [asd_pkg::CNT_BITS-1:0]   count_ff, count_in;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      cmd.sq_sel = count_ff[asd_pkg::SEL_BITS-1:0];
      case (state_ff)
         ST_IDLE: begin
            // no transfer is taken while reset is held
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               count_in = '0;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            if (count_ff == asd_pkg::CNT_BITS'(asd_pkg::NUM_AXES - 1)) begin
               count_in = '0;
               state_in = ST_ROOT;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         ST_ROOT: begin
            cmd.root = 1'b1;
            if (count_ff == asd_pkg::CNT_BITS'(asd_pkg::ROOT_BITS - 1)) begin
               count_in = '0;
               state_in = ST_NET;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         ST_NET: begin
            cmd.net  = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // wait for the output register to drain
            if (!status.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   `ASD_ASSERT_NEXT(a_load_starts_squares, clock, reset, cmd.load, state_ff == ST_SQUARE)
   `ASD_ASSERT_NOW(a_finish_when_free, clock, reset,
      (state_ff == ST_FINISH) && !status.out_busy, cmd.finish)
   `ASD_ASSERT_NEXT(a_finish_returns_idle, clock, reset, cmd.finish, state_ff == ST_IDLE)

endmodule

`default_nettype wire

/* hw/rtl/asd_datapath.sv */
// Datapath: config registers, shared square unit, iterative square root,
// net/threshold logic, hold-time state and the output register. Uses asd_pkg.
`default_nettype none
`include "accel_shake_detector_with_hold_assert.svh"

module asd_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  asd_pkg::asd_cmd_type                   cmd,
   output asd_pkg::asd_status_type                status,
   input  logic signed [asd_pkg::SAMPLE_BITS-1:0] req_accel_x,
   input  logic signed [asd_pkg::SAMPLE_BITS-1:0] req_accel_y,
   input  logic signed [asd_pkg::SAMPLE_BITS-1:0] req_accel_z,
   input  logic [asd_pkg::TIME_BITS-1:0]          req_time_ms,
   input  logic                                   csr_wr_en,
   input  logic [asd_pkg::IDX_BITS-1:0]           csr_index,
   input  logic [asd_pkg::CFG_BITS-1:0]           csr_wdata,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_shaken,
   output logic                                   rsp_shake_now,
   output logic [asd_pkg::NET_OUT_BITS-1:0]       rsp_net_accel,
   output logic                                   rsp_state_changed
);

   localparam int SB = asd_pkg::SAMPLE_BITS;
   localparam int TB = asd_pkg::TIME_BITS;
   localparam int RB = asd_pkg::ROOT_BITS;
   localparam int QB = asd_pkg::SQ_BITS;
   localparam int MB = asd_pkg::REM_BITS;
   localparam int NB = asd_pkg::NET_BITS;
   localparam int CB = asd_pkg::CFG_BITS;
   localparam int OB = asd_pkg::NET_OUT_BITS;

   // configuration
   logic [CB-1:0] gravity_ff, threshold_ff, hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff   <= asd_pkg::GRAVITY_RESET;
         threshold_ff <= asd_pkg::THRESHOLD_RESET;
         hold_ff      <= asd_pkg::HOLD_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            asd_pkg::REG_GRAVITY:   gravity_ff   <= csr_wdata;
            asd_pkg::REG_THRESHOLD: threshold_ff <= csr_wdata;
            asd_pkg::REG_HOLD:      hold_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sample capture: magnitudes of each axis fit SB unsigned bits
   logic [SB-1:0] abs_x_ff, abs_y_ff, abs_z_ff;
   logic [TB-1:0] now_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         abs_x_ff <= req_accel_x[SB-1] ? SB'(-req_accel_x) : SB'(req_accel_x);
         abs_y_ff <= req_accel_y[SB-1] ? SB'(-req_accel_y) : SB'(req_accel_y);
         abs_z_ff <= req_accel_z[SB-1] ? SB'(-req_accel_z) : SB'(req_accel_z);
         now_ff   <= req_time_ms;
      end
   end

   // shared multiplier, one axis per cycle
   logic [SB-1:0]   mul_op;
   logic [2*SB-1:0] mul_prod;

   always_comb begin
      case (cmd.sq_sel)
         asd_pkg::AXIS_X: mul_op = abs_x_ff;
         asd_pkg::AXIS_Y: mul_op = abs_y_ff;
         asd_pkg::AXIS_Z: mul_op = abs_z_ff;
         default:         mul_op = abs_z_ff;
      endcase
      mul_prod = mul_op * mul_op;
   end

   // sum of squares, then shifted out two bits per root step
   logic [QB-1:0] acc_ff;
   logic [MB-1:0] rem_ff, rem_sh, trial;
   logic [RB-1:0] root_ff;

   assign rem_sh = {rem_ff[MB-3:0], acc_ff[QB-1 -: 2]};
   assign trial  = MB'({root_ff, 2'b01});

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         acc_ff  <= '0;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.square) begin
         acc_ff <= acc_ff + QB'(mul_prod);
      end else if (cmd.root) begin
         acc_ff <= acc_ff << 2;
         if (rem_sh >= trial) begin
            rem_ff  <= rem_sh - trial;
            root_ff <= {root_ff[RB-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            root_ff <= {root_ff[RB-2:0], 1'b0};
         end
      end
   end

   // net acceleration, threshold and elapsed time since the old last shake
   logic [NB-1:0] mag_ext, grav_ext, net_w;
   logic [NB-1:0] net_ff;
   logic          hit_ff;
   logic [TB-1:0] elapsed_ff;

   assign mag_ext  = NB'(root_ff);
   assign grav_ext = NB'(gravity_ff);
   assign net_w    = (mag_ext >= grav_ext) ? (mag_ext - grav_ext) : (grav_ext - mag_ext);

   logic [TB-1:0] last_ff;
   logic          prev_shaken_ff;

   always_ff @(posedge clock) begin
      if (cmd.net) begin
         net_ff     <= net_w;
         hit_ff     <= (net_w > NB'(threshold_ff));
         elapsed_ff <= now_ff - last_ff;
      end
   end

   // a hit restarts the hold window: elapsed time is zero
   logic shaken_w;
   assign shaken_w = hit_ff ? (hold_ff != '0) : (elapsed_ff < TB'(hold_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff        <= '0;
         prev_shaken_ff <= 1'b0;
      end else if (cmd.finish) begin
         if (hit_ff) begin
            last_ff <= now_ff;
         end
         prev_shaken_ff <= shaken_w;
      end
   end

   // output register
   logic          rsp_valid_ff;
   logic          shaken_ff, shake_now_ff, changed_ff;
   logic [OB-1:0] net_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         shaken_ff    <= shaken_w;
         shake_now_ff <= hit_ff;
         changed_ff   <= shaken_w ^ prev_shaken_ff;
         net_out_ff   <= (net_ff > NB'({OB{1'b1}})) ? {OB{1'b1}} : OB'(net_ff);
      end
   end

   assign status.out_busy   = rsp_valid_ff && !rsp_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_shaken        = shaken_ff;
   assign rsp_shake_now     = shake_now_ff;
   assign rsp_net_accel     = net_out_ff;
   assign rsp_state_changed = changed_ff;

   `ASD_ASSERT_NEXT(a_finish_sets_valid, clock, reset, cmd.finish, rsp_valid_ff)
   `ASD_ASSERT_NEXT(a_hit_records_time, clock, reset,
      cmd.finish && hit_ff, last_ff == $past(now_ff))
   `ASD_ASSERT_NEXT(a_prev_tracks_output, clock, reset,
      cmd.finish, prev_shaken_ff == shaken_ff)

endmodule

`default_nettype wire

/* hw/rtl/accel_shake_detector_with_hold.sv */
// Accelerometer shake detector with hold time. Each request transfer carries one
// three-axis sample and a millisecond timestamp; one response transfer follows
// with shaken, shake_now, net_accel (|floor sqrt(x^2+y^2+z^2) - gravity|,
// saturated to 16 bits) and state_changed. A sample passes through three squaring
// steps on the shared multiplier, one step per root bit (SAMPLE_BITS + 1) in the
// iterative square root, the net/threshold stage and the finish step; a new
// request is taken only in the idle state that follows the finish step. The
// response valid is registered from the finish step. The result sits in an
// output register, so the next sample is accepted while it waits to be taken;
// the finish step of that next sample stalls for as long as the previous result
// is still waiting. Write configuration only while idle. Depends on asd_pkg,
// asd_req_if, asd_rsp_if, asd_ctrl and asd_datapath.
`default_nettype none

module accel_shake_detector_with_hold (
   input  logic                           clock,
   input  logic                           reset,
   asd_req_if.sink                        req_chan,
   asd_rsp_if.source                      rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [asd_pkg::IDX_BITS-1:0]   csr_index,
   input  logic [asd_pkg::CFG_BITS-1:0]   csr_wdata
);

   asd_pkg::asd_cmd_type    cmd;
   asd_pkg::asd_status_type status;

   asd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   asd_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_accel_x       (req_chan.accel_x),
      .req_accel_y       (req_chan.accel_y),
      .req_accel_z       (req_chan.accel_z),
      .req_time_ms       (req_chan.time_ms),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_shaken        (rsp_chan.shaken),
      .rsp_shake_now     (rsp_chan.shake_now),
      .rsp_net_accel     (rsp_chan.net_accel),
      .rsp_state_changed (rsp_chan.state_changed)
   );

endmodule

`default_nettype wire
